// ----- src/nsd_pkg.sv -----
// Package for the negative-selection detector check.
// Holds request and response types, verdict and opcode codes, CSR indexes
// and default sizes. No dependencies.
package nsd_pkg;

   localparam int STR_BITS_DEF   = 22;
   localparam int SELF_DEPTH_DEF = 256;

   localparam int VALUE_W   = 22;
   localparam int INDEX_W   = 8;
   localparam int WIDTH_W   = 6;
   localparam int WORD_W    = 32;
   localparam int IDX_EXT_W = 13;
   localparam int RMIN_W    = 5;
   localparam int RSPAN_W   = 5;
   localparam int COUNT_W   = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [RMIN_W-1:0]  RMIN_RESET  = 5'd8;
   localparam logic [RSPAN_W-1:0] RSPAN_RESET = 5'd5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   localparam logic [1:0] VERDICT_IN_SELF  = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
   localparam logic [1:0] VERDICT_REJECTED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_R_MIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_R_SPAN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_COUNT = 2'd2;

   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] self_index;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] candidate;
      logic [1:0]         verdict;
      logic [WIDTH_W-1:0] detector_width;
   } rsp_type;

   // control of the shared compare unit
   typedef struct packed {
      logic               eq_mode;
      logic [WIDTH_W-1:0] width;
   } unit_ctrl_type;

endpackage

// ----- src/negative_selection_detector_check.sv -----
// Top level of the negative-selection r-chunk detector check.
// Depends on nsd_pkg, nsd_self_mem and nsd_window_unit.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+--------------------------------
//  request | start, busy, req_data (req_type)   | taken when start & !busy
//  result  | rsp_strobe, rsp_data (rsp_type)    | one cycle strobe, never held
//  csr     | csr_we, csr_index, csr_wdata       | written when csr_we is high
//
// A load request is written to the store at once and never raises busy.
// A test runs an equality pass, then one pass per window width tried; a pass
// reads the n valid entries one after another through the one store read
// port into the shared compare unit. The result strobe follows
// the last pass. Reset clears the sequencer and the CSRs, not the store.
// The receiver cannot stall: each result shows for exactly one cycle.
module negative_selection_detector_check #(
   parameter int STR_BITS   = nsd_pkg::STR_BITS_DEF,
   parameter int SELF_DEPTH = nsd_pkg::SELF_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  nsd_pkg::req_type                    req_data,
   output logic                                rsp_strobe,
   output nsd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [nsd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [nsd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ADDR_W = (SELF_DEPTH > 1) ? $clog2(SELF_DEPTH) : 1;
   localparam int CNT_W  = $clog2(SELF_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_EQ, S_WIN} state_type;

   state_type                          state_ff;
   logic [nsd_pkg::RMIN_W-1:0]         r_min_ff;
   logic [nsd_pkg::RSPAN_W-1:0]        r_span_ff;
   logic [nsd_pkg::COUNT_W-1:0]        self_count_ff;

   logic [STR_BITS-1:0]                cand_ff;
   logic [CNT_W-1:0]                   n_ff;
   logic [CNT_W-1:0]                   iss_cnt_ff;
   logic                               rd_v_ff;
   logic                               cmp_v_ff;
   logic                               match_ff;
   logic                               hit_ff;
   logic [nsd_pkg::WIDTH_W-1:0]        r_ff;
   logic [nsd_pkg::RSPAN_W-1:0]        left_ff;
   logic                               rsp_strobe_ff;
   nsd_pkg::rsp_type                   rsp_data_ff;

   logic [nsd_pkg::WORD_W-1:0]         val_ext;
   logic [STR_BITS-1:0]                val_str;
   logic [nsd_pkg::WORD_W-1:0]         cand_ext;
   logic [nsd_pkg::IDX_EXT_W-1:0]      idx_ext;
   logic [nsd_pkg::IDX_EXT_W-1:0]      cnt_ext;
   logic [nsd_pkg::IDX_EXT_W-1:0]      n_ext;
   logic                               accept;
   logic                               load_en;
   logic                               issue;
   logic                               pass_done;
   logic                               hit_all;
   logic [STR_BITS-1:0]                rd_data;
   logic                               unit_hit;
   nsd_pkg::unit_ctrl_type             unit_ctrl;

   // Narrow or widen the request value to the string width.
   assign val_ext  = nsd_pkg::WORD_W'(req_data.value);
   assign val_str  = val_ext[STR_BITS-1:0];
   assign cand_ext = nsd_pkg::WORD_W'(cand_ff);

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;

   // Drop loads aimed beyond the store.
   assign idx_ext = nsd_pkg::IDX_EXT_W'(req_data.self_index);
   assign load_en = accept && (req_data.op == nsd_pkg::OP_LOAD) &&
                    (idx_ext < nsd_pkg::IDX_EXT_W'(SELF_DEPTH));

   // Clamp the valid count to the store depth.
   assign cnt_ext = nsd_pkg::IDX_EXT_W'(self_count_ff);
   assign n_ext   = (cnt_ext > nsd_pkg::IDX_EXT_W'(SELF_DEPTH)) ?
                    nsd_pkg::IDX_EXT_W'(SELF_DEPTH) : cnt_ext;

   // One read issued per cycle until every valid entry is out; the pass ends
   // once the read and compare stages have drained.
   assign issue     = busy && (iss_cnt_ff < n_ff);
   assign pass_done = busy && !issue && !rd_v_ff && !cmp_v_ff;
   assign hit_all   = hit_ff;

   assign unit_ctrl.eq_mode = (state_ff == S_EQ);
   assign unit_ctrl.width   = r_ff;

   nsd_self_mem #(
      .STR_BITS  (STR_BITS),
      .SELF_DEPTH(SELF_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (load_en),
      .wr_addr   (idx_ext[ADDR_W-1:0]),
      .wr_data   (val_str),
      .rd_addr   (iss_cnt_ff[ADDR_W-1:0]),
      .rd_data_ff(rd_data)
   );

   nsd_window_unit #(
      .STR_BITS(STR_BITS)
   ) u_unit (
      .ctrl (unit_ctrl),
      .cand (cand_ff),
      .entry(rd_data),
      .hit  (unit_hit)
   );

   // CSR writes; out-of-list indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         r_min_ff      <= nsd_pkg::RMIN_RESET;
         r_span_ff     <= nsd_pkg::RSPAN_RESET;
         self_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            nsd_pkg::CSR_R_MIN:      r_min_ff      <= csr_wdata[nsd_pkg::RMIN_W-1:0];
            nsd_pkg::CSR_R_SPAN:     r_span_ff     <= csr_wdata[nsd_pkg::RSPAN_W-1:0];
            nsd_pkg::CSR_SELF_COUNT: self_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: state, pass pipeline and the registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         iss_cnt_ff    <= '0;
         rd_v_ff       <= 1'b0;
         cmp_v_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rd_v_ff       <= issue;
         cmp_v_ff      <= rd_v_ff;
         if (issue) begin
            iss_cnt_ff <= iss_cnt_ff + 1'b1;
         end
         if (cmp_v_ff && match_ff) begin
            hit_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req_data.op == nsd_pkg::OP_TEST)) begin
                  state_ff   <= S_EQ;
                  cand_ff    <= val_str;
                  n_ff       <= n_ext[CNT_W-1:0];
                  iss_cnt_ff <= '0;
                  hit_ff     <= 1'b0;
               end
            end
            S_EQ: begin
               if (pass_done) begin
                  // restart the pass counter for the first width
                  iss_cnt_ff <= '0;
                  hit_ff     <= 1'b0;
                  r_ff       <= nsd_pkg::WIDTH_W'(r_min_ff);
                  left_ff    <= r_span_ff;
                  if (hit_all) begin
                     state_ff                   <= S_IDLE;
                     rsp_strobe_ff              <= 1'b1;
                     rsp_data_ff.verdict        <= nsd_pkg::VERDICT_IN_SELF;
                     rsp_data_ff.detector_width <= '0;
                     rsp_data_ff.candidate      <= cand_ext[nsd_pkg::VALUE_W-1:0];
                  end else if (r_span_ff == '0) begin
                     state_ff                   <= S_IDLE;
                     rsp_strobe_ff              <= 1'b1;
                     rsp_data_ff.verdict        <= nsd_pkg::VERDICT_REJECTED;
                     rsp_data_ff.detector_width <= '0;
                     rsp_data_ff.candidate      <= cand_ext[nsd_pkg::VALUE_W-1:0];
                  end else begin
                     state_ff <= S_WIN;
                  end
               end
            end
            S_WIN: begin
               if (pass_done) begin
                  iss_cnt_ff <= '0;
                  hit_ff     <= 1'b0;
                  priority if (!hit_all) begin
                     // no entry shares a window of this width: accept it
                     state_ff                   <= S_IDLE;
                     rsp_strobe_ff              <= 1'b1;
                     rsp_data_ff.verdict        <= nsd_pkg::VERDICT_ACCEPTED;
                     rsp_data_ff.detector_width <= r_ff;
                     rsp_data_ff.candidate      <= cand_ext[nsd_pkg::VALUE_W-1:0];
                  end else if (left_ff == nsd_pkg::RSPAN_W'(1)) begin
                     state_ff                   <= S_IDLE;
                     rsp_strobe_ff              <= 1'b1;
                     rsp_data_ff.verdict        <= nsd_pkg::VERDICT_REJECTED;
                     rsp_data_ff.detector_width <= '0;
                     rsp_data_ff.candidate      <= cand_ext[nsd_pkg::VALUE_W-1:0];
                  end else begin
                     // advance to the next width
                     r_ff    <= r_ff + 1'b1;
                     left_ff <= left_ff - 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Register the compare result ahead of the accumulation.
   always_ff @(posedge clock) begin
      match_ff <= unit_hit;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- src/nsd_self_mem.sv -----
// Self string store: one write port, one registered read port.
// Depends on nothing but its parameters.
module nsd_self_mem #(
   parameter int STR_BITS   = 22,
   parameter int SELF_DEPTH = 256,
   parameter int ADDR_W     = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [STR_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [STR_BITS-1:0] rd_data_ff
);

   logic [STR_BITS-1:0] mem [SELF_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- src/nsd_window_unit.sv -----
// Shared compare unit: full equality, or any r-bit window pair match.
// Depends on nsd_pkg for the control struct.
module nsd_window_unit #(
   parameter int STR_BITS = 22
) (
   input  nsd_pkg::unit_ctrl_type ctrl,
   input  logic [STR_BITS-1:0]    cand,
   input  logic [STR_BITS-1:0]    entry,
   output logic                   hit
);

   localparam int CMP_W = 7;

   logic [STR_BITS-1:0] mask;
   logic [CMP_W-1:0]    r_ext;
   logic                win_hit;

   assign r_ext = CMP_W'(ctrl.width);

   always_comb begin
      mask    = '0;
      win_hit = 1'b0;
      for (int b = 0; b < STR_BITS; b++) begin
         mask[b] = (CMP_W'(b) < r_ext);
      end
      // every offset pair whose windows fit inside the string
      for (int i = 0; i < STR_BITS; i++) begin
         for (int j = 0; j < STR_BITS; j++) begin
            if ((CMP_W'(i) + r_ext <= CMP_W'(STR_BITS)) &&
                (CMP_W'(j) + r_ext <= CMP_W'(STR_BITS))) begin
               if (((cand >> i) & mask) == ((entry >> j) & mask)) begin
                  win_hit = 1'b1;
               end
            end
         end
      end
   end

   assign hit = ctrl.eq_mode ? (cand == entry) : win_hit;

endmodule

// ----- bench/detector_verdict_monitor.sv -----
// Verdict monitor for the negative-selection detector check: mirrors the self
// store and the CSRs, predicts one verdict per test request and compares.
// Depends on nsd_pkg.
module detector_verdict_monitor
   import nsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_strobe,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           verdict_faults,
   output int unsigned           verdicts_owed
);

   localparam int STR_BITS   = STR_BITS_DEF;
   localparam int SELF_DEPTH = SELF_DEPTH_DEF;

   logic [VALUE_W-1:0] self_mirror [SELF_DEPTH];
   logic [RMIN_W-1:0]  win_lo;
   logic [RSPAN_W-1:0] win_span;
   logic [COUNT_W-1:0] valid_count;
   rsp_type            owed_verdicts [$];
   int unsigned        fault_tally;

   initial begin
      verdict_faults = 0;
      verdicts_owed  = 0;
      fault_tally    = 0;
   end

   // Equality pass first, then one window width after another; a width with
   // no shared chunk against any valid entry is the detector width.
   function automatic rsp_type judge_candidate(input logic [VALUE_W-1:0] cand);
      rsp_type     outcome;
      int          live;
      int          width;
      bit          hit;
      logic [31:0] mask;
      int unsigned chunk;
      bit          cand_chunks [int unsigned];
      outcome.candidate      = cand;
      outcome.verdict        = VERDICT_REJECTED;
      outcome.detector_width = '0;
      live = (valid_count > SELF_DEPTH) ? SELF_DEPTH : int'(valid_count);
      for (int e = 0; e < live; e++) begin
         if (self_mirror[e] == cand) begin
            outcome.verdict = VERDICT_IN_SELF;
            return outcome;
         end
      end
      for (int k = 0; k < int'(win_span); k++) begin
         width = int'(win_lo) + k;
         hit   = 1'b0;
         // widths beyond the string have no windows and never match
         if (width <= STR_BITS) begin
            mask = (32'h1 << width) - 32'h1;
            cand_chunks.delete();
            for (int i = 0; i + width <= STR_BITS; i++) begin
               chunk = (32'(cand) >> i) & mask;
               cand_chunks[chunk] = 1'b1;
            end
            for (int e = 0; e < live && !hit; e++) begin
               for (int j = 0; j + width <= STR_BITS && !hit; j++) begin
                  chunk = (32'(self_mirror[e]) >> j) & mask;
                  if (cand_chunks.exists(chunk))
                     hit = 1'b1;
               end
            end
         end
         if (!hit) begin
            outcome.verdict        = VERDICT_ACCEPTED;
            outcome.detector_width = WIDTH_W'(width);
            return outcome;
         end
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         win_lo      <= RMIN_RESET;
         win_span    <= RSPAN_RESET;
         valid_count <= '0;
         owed_verdicts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_R_MIN:      win_lo      <= csr_wdata[RMIN_W-1:0];
               CSR_R_SPAN:     win_span    <= csr_wdata[RSPAN_W-1:0];
               CSR_SELF_COUNT: valid_count <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         // retire the result first: a request taken on this edge cannot own it
         if (rsp_strobe) begin
            if (owed_verdicts.size() == 0) begin
               $error("unexpected verdict for candidate %h", rsp_data.candidate);
               fault_tally++;
            end else begin
               due = owed_verdicts.pop_front();
               if (rsp_data.candidate !== due.candidate) begin
                  $error("candidate: expected %h, got %h", due.candidate, rsp_data.candidate);
                  fault_tally++;
               end
               if (rsp_data.verdict !== due.verdict) begin
                  $error("verdict: expected %0d, got %0d", due.verdict, rsp_data.verdict);
                  fault_tally++;
               end
               if (rsp_data.detector_width !== due.detector_width) begin
                  $error("detector_width: expected %0d, got %0d",
                         due.detector_width, rsp_data.detector_width);
                  fault_tally++;
               end
            end
         end
         if (start && !busy) begin
            if (req_data.op == OP_LOAD)
               self_mirror[req_data.self_index] <= req_data.value;
            else
               owed_verdicts.push_back(judge_candidate(req_data.value));
         end
      end
      verdict_faults <= fault_tally;
      verdicts_owed  <= owed_verdicts.size();
   end

endmodule

// ----- bench/negative_selection_detector_check_tb.sv -----
// Testbench top for the negative-selection detector check: clock, reset,
// request and CSR stimulus, and the final verdict.
// Depends on nsd_pkg, negative_selection_detector_check, detector_verdict_monitor.
module negative_selection_detector_check_tb;
   import nsd_pkg::*;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int unsigned           verdict_faults;
   int unsigned           verdicts_owed;

   // Stimulus-side copy of what each slot was loaded with, so that
   // candidates can be built close to the self set.
   logic [VALUE_W-1:0] slot_value  [SELF_DEPTH_DEF];
   bit                 slot_loaded [SELF_DEPTH_DEF];

   always #10 clock = ~clock;

   negative_selection_detector_check dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   detector_verdict_monitor verdict_watch (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .verdict_faults (verdict_faults),
      .verdicts_owed  (verdicts_owed)
   );

   // Write one CSR, then drop the enable and hold it low over the next edge so that back-to-back
   // writes never lower and raise it on the same edge.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Hold start low for the gap, then present the request and hold it
   // until an edge sees start high with busy low. Start stays high on
   // return so that the next request may follow without a bubble.
   task automatic issue_request(input logic op, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val, input int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{op: op, self_index: idx, value: val};
      do @(posedge clock); while (busy);
      if (op == OP_LOAD) begin
         slot_value[idx]  = val;
         slot_loaded[idx] = 1'b1;
      end
   endtask

   // Drop start and wait until every verdict is in and the block is idle;
   // spare cycles after that cover a load still settling into the store.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (verdicts_owed != 0 || busy);
      repeat (20) @(posedge clock);
   endtask

   // Idle cycles before a request: each cycle is skipped with the given
   // percentage, capped so a single gap stays short.
   function automatic int unsigned pick_gap(input int unsigned pct);
      int unsigned g;
      g = 0;
      while (g < 60 && $urandom_range(99) < pct)
         g++;
      return g;
   endfunction

   // Build a string: extremes, plain random, or a copy, a one-bit flip or a
   // shifted image of one of the first 'live' slots (all of them loaded).
   function automatic logic [VALUE_W-1:0] pick_candidate(input int unsigned count);
      int unsigned        live;
      int unsigned        kind;
      int unsigned        s;
      logic [VALUE_W-1:0] e;
      logic [VALUE_W-1:0] v;
      live = (count > SELF_DEPTH_DEF) ? SELF_DEPTH_DEF : count;
      kind = $urandom_range(9);
      v    = VALUE_W'($urandom);
      if (kind == 0)
         v = $urandom_range(1) ? '1 : '0;
      else if (kind >= 4 && live != 0) begin
         e = slot_value[$urandom_range(live - 1)];
         s = $urandom_range(1, 3);
         case (kind)
            4, 5:    v = e;
            6, 7:    v = e ^ (VALUE_W'(1) << $urandom_range(VALUE_W - 1));
            8:       v = VALUE_W'((e << s) | ($urandom & ((32'h1 << s) - 1)));
            default: v = VALUE_W'((e >> s) | (VALUE_W'($urandom) << (VALUE_W - s)));
         endcase
      end
      return v;
   endfunction

   initial begin
      int unsigned rmin;
      int unsigned span;
      int unsigned count;
      int unsigned pct;
      int unsigned gap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Empty store with reset settings: first width taken.
      issue_request(OP_TEST, 8'h00, '0, 0);
      issue_request(OP_TEST, 8'hFF, '1, 0);
      issue_request(OP_LOAD, 8'h00, '0, 0);
      issue_request(OP_LOAD, 8'h01, '1, 0);
      issue_request(OP_LOAD, 8'h02, 22'h155555, 0);
      issue_request(OP_LOAD, 8'h03, 22'h0F0F0F, 0);
      issue_request(OP_LOAD, 8'hFF, 22'h2AAAAA, 0);
      settle();
      csr_write(CSR_SELF_COUNT, 4);
      // exact hits, an alternating pattern sharing every chunk, near misses
      issue_request(OP_TEST, 8'h00, '0, 0);
      issue_request(OP_TEST, 8'h00, '1, 0);
      issue_request(OP_TEST, 8'h00, 22'h2AAAAA, 0);
      issue_request(OP_TEST, 8'h00, 22'h000001, 0);
      issue_request(OP_TEST, 8'h00, 22'h1E1E1E, 0);
      // zero width matches any valid entry
      settle();
      csr_write(CSR_R_MIN, 0);
      issue_request(OP_TEST, 8'h00, 22'h3A5C17, 0);
      // first width already beyond the string
      settle();
      csr_write(CSR_R_MIN, 23);
      issue_request(OP_TEST, 8'h00, 22'h12345F, 0);
      // lowest width and span both at their top
      settle();
      csr_write(CSR_R_MIN, 31);
      csr_write(CSR_R_SPAN, 31);
      issue_request(OP_TEST, 8'h00, 22'h0ABCDE, 0);
      // no width tried at all
      settle();
      csr_write(CSR_R_SPAN, 0);
      issue_request(OP_TEST, 8'h00, 22'h3C3C3C, 0);

      // Random phases: each picks a setting, fills the valid slots, then
      // mixes loads and tests. Idling rotates through none, heavy and light.
      for (int p = 0; p < 13; p++) begin
         case (p)
            0:       begin rmin = 1;  span = 31; count = 4;   end
            1:       begin rmin = 31; span = 1;  count = 6;   end
            2:       begin rmin = 0;  span = 3;  count = 2;   end
            3:       begin rmin = 8;  span = 5;  count = 256; end
            4:       begin rmin = 22; span = 2;  count = 511; end
            5:       begin rmin = $urandom_range(5, 14); span = 0; count = 3; end
            6:       begin rmin = $urandom_range(5, 14); span = 4; count = 0; end
            default: begin
               rmin  = $urandom_range(5, 14);
               span  = $urandom_range(1, 8);
               count = $urandom_range(1, 16);
            end
         endcase
         case (p % 3)
            0:       pct = 0;
            1:       pct = 80;
            default: pct = 6;
         endcase
         settle();
         csr_write(CSR_R_MIN, rmin);
         csr_write(CSR_R_SPAN, span);
         csr_write(CSR_SELF_COUNT, count);
         // load every valid slot not yet written before any test reads it
         for (int s = 0; s < SELF_DEPTH_DEF && s < int'(count); s++) begin
            if (!slot_loaded[s])
               issue_request(OP_LOAD, INDEX_W'(s), pick_candidate(s), pick_gap(pct));
         end
         for (int i = 0; i < 15; i++) begin
            // keep a short run at full rate at the top of every dozen
            gap = (i % 12 < 3) ? 0 : pick_gap(pct);
            if ($urandom_range(99) < 30)
               issue_request(OP_LOAD, INDEX_W'($urandom_range(255)), pick_candidate(count), gap);
            else
               issue_request(OP_TEST, INDEX_W'($urandom_range(255)), pick_candidate(count), gap);
         end
      end

      settle();
      if (verdict_faults == 0 && verdicts_owed == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Hold a hard ceiling on the run well past the slowest expected finish.
   initial begin
      #30_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
src/nsd_pkg.sv
src/nsd_self_mem.sv
src/nsd_window_unit.sv
src/negative_selection_detector_check.sv
bench/detector_verdict_monitor.sv
bench/negative_selection_detector_check_tb.sv
